### design/snx3_pkg.sv
`default_nettype none
package snx3_pkg;

    localparam int PERM_ENTRIES = 256;
    localparam int PERM_AW      = $clog2(PERM_ENTRIES);

    localparam int FX_W = 64;

    // raw Q32.32 constants
    localparam logic [FX_W-1:0] FX_ONE     = 64'h0000_0001_0000_0000;
    localparam logic [FX_W-1:0] FX_F3      = 64'd1431655765;
    localparam logic [FX_W-1:0] FX_G3      = 64'd715827882;
    localparam logic [FX_W-1:0] FX_G3X2    = 64'd1431655764;
    localparam logic [FX_W-1:0] FX_G3X3    = 64'd2147483646;
    localparam logic [FX_W-1:0] FX_FALLOFF = 64'd2576980377;

    // multiplier sequence: four partial products, then sign correction
    localparam logic [2:0] MUL_LAST_STEP = 3'd4;

    typedef struct packed {
        logic            start;
        logic [FX_W-1:0] a;
        logic [FX_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic            done;
        logic [FX_W-1:0] p;
    } mul_rsp_t;

    localparam logic [1:0] GRAD_ZERO = 2'b00;
    localparam logic [1:0] GRAD_POS  = 2'b01;
    localparam logic [1:0] GRAD_NEG  = 2'b10;

    typedef struct packed {
        logic [1:0] gx;
        logic [1:0] gy;
        logic [1:0] gz;
    } grad_t;

    // byte mod 12 by conditional subtraction
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        if (r >= 8'd12)  r = r - 8'd12;
        return r[3:0];
    endfunction

    // twelve cube-edge gradients
    function automatic grad_t edge_grad(input logic [3:0] g);
        grad_t r;
        r = '{gx: GRAD_ZERO, gy: GRAD_ZERO, gz: GRAD_ZERO};
        unique case (g)
            4'd0:  r = '{gx: GRAD_POS,  gy: GRAD_POS,  gz: GRAD_ZERO};
            4'd1:  r = '{gx: GRAD_NEG,  gy: GRAD_POS,  gz: GRAD_ZERO};
            4'd2:  r = '{gx: GRAD_POS,  gy: GRAD_NEG,  gz: GRAD_ZERO};
            4'd3:  r = '{gx: GRAD_NEG,  gy: GRAD_NEG,  gz: GRAD_ZERO};
            4'd4:  r = '{gx: GRAD_POS,  gy: GRAD_ZERO, gz: GRAD_POS};
            4'd5:  r = '{gx: GRAD_NEG,  gy: GRAD_ZERO, gz: GRAD_POS};
            4'd6:  r = '{gx: GRAD_POS,  gy: GRAD_ZERO, gz: GRAD_NEG};
            4'd7:  r = '{gx: GRAD_NEG,  gy: GRAD_ZERO, gz: GRAD_NEG};
            4'd8:  r = '{gx: GRAD_ZERO, gy: GRAD_POS,  gz: GRAD_POS};
            4'd9:  r = '{gx: GRAD_ZERO, gy: GRAD_NEG,  gz: GRAD_POS};
            4'd10: r = '{gx: GRAD_ZERO, gy: GRAD_POS,  gz: GRAD_NEG};
            4'd11: r = '{gx: GRAD_ZERO, gy: GRAD_NEG,  gz: GRAD_NEG};
            default: r = '{gx: GRAD_ZERO, gy: GRAD_ZERO, gz: GRAD_ZERO};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### design/snx3_mul.sv
`default_nettype none
// signed Q32.32 multiply, floor, low 64 bits; one 32x32 product per cycle
module snx3_mul (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  snx3_pkg::mul_req_t  req,
    output snx3_pkg::mul_rsp_t  rsp
);
    import snx3_pkg::*;

    logic            busy_reg;
    logic            done_reg;
    logic [2:0]      step_reg;
    logic [FX_W-1:0] a_reg;
    logic [FX_W-1:0] b_reg;
    logic [95:0]     acc_reg;
    logic [95:0]     acc_next;
    logic [31:0]     pa;
    logic [31:0]     pb;
    logic [63:0]     prod;
    logic [31:0]     corr;

    always_comb begin
        pa   = (step_reg == 3'd2 || step_reg == 3'd3) ? a_reg[63:32] : a_reg[31:0];
        pb   = (step_reg == 3'd1 || step_reg == 3'd3) ? b_reg[63:32] : b_reg[31:0];
        prod = pa * pb;
        corr = (a_reg[63] ? b_reg[31:0] : 32'd0) + (b_reg[63] ? a_reg[31:0] : 32'd0);
        unique case (step_reg)
            3'd0:    acc_next = acc_reg + {32'd0, prod};
            3'd1,
            3'd2:    acc_next = acc_reg + {prod, 32'd0};
            3'd3:    acc_next = acc_reg + {prod[31:0], 64'd0};
            default: acc_next = acc_reg - {corr, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= busy_reg && (step_reg == MUL_LAST_STEP);
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == MUL_LAST_STEP) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg[95:32];

endmodule
`default_nettype wire

### design/simplex_noise_3d_fixed.sv
`default_nettype none
// 3D simplex noise, signed Q32.32.
// Input stream (s_*): s_tuser[0] is the opcode. Opcode 0 is a table load:
// table_value is written to permutation entry table_index and no result
// is produced. Opcode 1 is a sample of point (x, y, z); one
// transfer on the m_* stream carries the noise value.
// The permutation table must be loaded before sampling; it is not cleared
// by reset. Reset returns the sequencer to idle and drops any pending result.
// A sample runs through one shared 64x64 multiplier built from a single
// 32x32 product per cycle: each multiply passes through start, five steps
// and done. A sample needs 2 multiplies for skew/unskew plus 3 to 6 per
// corner, perm reads and bookkeeping per corner and the output state.
// s_tready is high only while idle; one sample is in flight, so a new
// sample is taken only once the last one has gone to the output register.
// Loads can follow each other every cycle while the block is idle.
// A finished result sits in the output register until m_tready; the block
// stays busy (not ready) until that result can be loaded.
module simplex_noise_3d_fixed (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // x_coord[63:0], y_coord[127:64], z_coord[191:128],
    // table_index[199:192], table_value[207:200]
    input  wire  [207:0] s_tdata,
    // opcode[0]
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // noise_value[63:0]
    output logic [63:0]  m_tdata
);
    import snx3_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_SKEW  = 17'h00002,
        S_CELL  = 17'h00004,
        S_OFFS  = 17'h00008,
        S_CSET  = 17'h00010,
        S_SQ1   = 17'h00020,
        S_SQ2   = 17'h00040,
        S_SQ3   = 17'h00080,
        S_T4    = 17'h00100,
        S_PERM0 = 17'h00200,
        S_PERM1 = 17'h00400,
        S_PERM2 = 17'h00800,
        S_PERM3 = 17'h01000,
        S_CACC  = 17'h02000,
        S_CNEXT = 17'h04000,
        S_OUT   = 17'h08000,
        S_MUL   = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [FX_W-1:0] x_reg, y_reg, z_reg;
    logic [FX_W-1:0] x0_reg, y0_reg, z0_reg;
    logic [FX_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [FX_W-1:0] tacc_reg, t4_reg, sum_reg;
    logic [31:0]     ci_reg, cj_reg, ck_reg;
    logic [2:0]      o1_reg, o2_reg;          // {i,j,k} offsets of corners 1, 2
    logic [1:0]      corner_reg;
    logic [PERM_AW-1:0] gi_reg, gj_reg, gk_reg;
    logic            m_tvalid_reg;
    logic [63:0]     m_tdata_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    // permutation table
    logic [7:0]         perm_mem [PERM_ENTRIES];
    logic [7:0]         rd_reg;
    logic [PERM_AW-1:0] rd_addr;
    logic               wr_en;

    logic            s_xfer;
    logic [31:0]     ci_n, cj_n, ck_n;
    logic [FX_W-1:0] x0_n, y0_n, z0_n;
    logic            ge_xy, ge_yz, ge_xz;
    logic [2:0]      o1_n, o2_n, ofs;
    logic [FX_W-1:0] add_n, t_n, dot_n;
    grad_t           gr;
    logic            out_load;

    snx3_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign wr_en    = s_xfer && !s_tuser[0];

    always_comb begin
        if (state_reg == S_PERM1)      rd_addr = gj_reg + rd_reg;
        else if (state_reg == S_PERM2) rd_addr = gi_reg + rd_reg;
        else                           rd_addr = gk_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) perm_mem[s_tdata[199:192]] <= s_tdata[207:200];
        rd_reg <= perm_mem[rd_addr];
    end

    // datapath helpers
    always_comb begin
        ci_n  = x_reg[63:32] + mrsp.p[63:32] + {31'd0, (x_reg[31:0] + mrsp.p[31:0]) < x_reg[31:0]};
        cj_n  = y_reg[63:32] + mrsp.p[63:32] + {31'd0, (y_reg[31:0] + mrsp.p[31:0]) < y_reg[31:0]};
        ck_n  = z_reg[63:32] + mrsp.p[63:32] + {31'd0, (z_reg[31:0] + mrsp.p[31:0]) < z_reg[31:0]};
        x0_n  = x_reg - ({ci_reg, 32'd0} - mrsp.p);
        y0_n  = y_reg - ({cj_reg, 32'd0} - mrsp.p);
        z0_n  = z_reg - ({ck_reg, 32'd0} - mrsp.p);
        ge_xy = $signed(x0_n) >= $signed(y0_n);
        ge_yz = $signed(y0_n) >= $signed(z0_n);
        ge_xz = $signed(x0_n) >= $signed(z0_n);
        if (ge_xy) begin
            if (ge_yz)      begin o1_n = 3'b100; o2_n = 3'b110; end
            else if (ge_xz) begin o1_n = 3'b100; o2_n = 3'b101; end
            else            begin o1_n = 3'b001; o2_n = 3'b101; end
        end else begin
            if (!ge_yz)     begin o1_n = 3'b001; o2_n = 3'b011; end
            else if (!ge_xz)begin o1_n = 3'b010; o2_n = 3'b011; end
            else            begin o1_n = 3'b010; o2_n = 3'b110; end
        end
        unique case (corner_reg)
            2'd0:    begin ofs = 3'b000; add_n = '0;      end
            2'd1:    begin ofs = o1_reg; add_n = FX_G3;   end
            2'd2:    begin ofs = o2_reg; add_n = FX_G3X2; end
            default: begin ofs = 3'b111; add_n = FX_G3X3; end
        endcase
        t_n = tacc_reg - mrsp.p;
        gr  = edge_grad(mod12(rd_reg));
        dot_n = '0;
        if (gr.gx == GRAD_POS) dot_n = dot_n + dx_reg;
        else if (gr.gx == GRAD_NEG) dot_n = dot_n - dx_reg;
        if (gr.gy == GRAD_POS) dot_n = dot_n + dy_reg;
        else if (gr.gy == GRAD_NEG) dot_n = dot_n - dy_reg;
        if (gr.gz == GRAD_POS) dot_n = dot_n + dz_reg;
        else if (gr.gz == GRAD_NEG) dot_n = dot_n - dz_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        mreq.start = 1'b0;
        mreq.a     = '0;
        mreq.b     = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: if (s_xfer && s_tuser[0]) state_next = S_SKEW;
            S_SKEW: begin
                mreq = '{start: 1'b1, a: x_reg + y_reg + z_reg, b: FX_F3};
                ret_next = S_CELL; state_next = S_MUL;
            end
            S_CELL: begin
                mreq = '{start: 1'b1, a: {ci_n + cj_n + ck_n, 32'd0}, b: FX_G3};
                ret_next = S_OFFS; state_next = S_MUL;
            end
            S_OFFS: state_next = S_CSET;
            S_CSET: begin
                mreq = '{start: 1'b1,
                         a: x0_reg - (ofs[2] ? FX_ONE : '0) + add_n,
                         b: x0_reg - (ofs[2] ? FX_ONE : '0) + add_n};
                ret_next = S_SQ1; state_next = S_MUL;
            end
            S_SQ1: begin
                mreq = '{start: 1'b1, a: dy_reg, b: dy_reg};
                ret_next = S_SQ2; state_next = S_MUL;
            end
            S_SQ2: begin
                mreq = '{start: 1'b1, a: dz_reg, b: dz_reg};
                ret_next = S_SQ3; state_next = S_MUL;
            end
            S_SQ3: begin
                if (t_n[63]) begin
                    state_next = S_CNEXT;
                end else begin
                    mreq = '{start: 1'b1, a: t_n, b: t_n};
                    ret_next = S_T4; state_next = S_MUL;
                end
            end
            S_T4: begin
                mreq = '{start: 1'b1, a: mrsp.p, b: mrsp.p};
                ret_next = S_PERM0; state_next = S_MUL;
            end
            S_PERM0: state_next = S_PERM1;
            S_PERM1: state_next = S_PERM2;
            S_PERM2: state_next = S_PERM3;
            S_PERM3: begin
                mreq = '{start: 1'b1, a: t4_reg, b: dot_n};
                ret_next = S_CACC; state_next = S_MUL;
            end
            S_CACC:  state_next = S_CNEXT;
            S_CNEXT: state_next = (corner_reg == 2'd3) ? S_OUT : S_CSET;
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL: if (mrsp.done) state_next = ret_reg;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            x_reg <= s_tdata[63:0];
            y_reg <= s_tdata[127:64];
            z_reg <= s_tdata[191:128];
        end
        unique case (state_reg)
            S_CELL: begin
                ci_reg <= ci_n;
                cj_reg <= cj_n;
                ck_reg <= ck_n;
            end
            S_OFFS: begin
                x0_reg     <= x0_n;
                y0_reg     <= y0_n;
                z0_reg     <= z0_n;
                o1_reg     <= o1_n;
                o2_reg     <= o2_n;
                corner_reg <= 2'd0;
                sum_reg    <= '0;
            end
            S_CSET: begin
                dx_reg   <= x0_reg - (ofs[2] ? FX_ONE : '0) + add_n;
                dy_reg   <= y0_reg - (ofs[1] ? FX_ONE : '0) + add_n;
                dz_reg   <= z0_reg - (ofs[0] ? FX_ONE : '0) + add_n;
                gi_reg   <= ci_reg[PERM_AW-1:0] + {{(PERM_AW-1){1'b0}}, ofs[2]};
                gj_reg   <= cj_reg[PERM_AW-1:0] + {{(PERM_AW-1){1'b0}}, ofs[1]};
                gk_reg   <= ck_reg[PERM_AW-1:0] + {{(PERM_AW-1){1'b0}}, ofs[0]};
                tacc_reg <= FX_FALLOFF;
            end
            S_SQ1, S_SQ2: tacc_reg <= t_n;
            S_PERM0: t4_reg  <= mrsp.p;
            S_CACC:  sum_reg <= sum_reg + mrsp.p;
            S_CNEXT: corner_reg <= corner_reg + 2'd1;
            S_OUT:   if (out_load) m_tdata_reg <= {sum_reg[58:0], 5'd0};
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a sample transfer always takes the block busy
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("ready after sample accepted");

    // multiplier completes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> (state_reg == S_MUL))
        else $error("multiplier done outside wait state");

    // a new result comes only from the output state
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // no multiply is started while one is in flight
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL && !mrsp.done) |-> !mreq.start)
        else $error("multiplier restarted while busy");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import snx3_pkg::*;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    wire          s_tready;
    logic [207:0] s_tdata;
    logic [0:0]   s_tuser;
    wire          m_tvalid;
    logic         m_tready;
    wire  [63:0]  m_tdata;

    simplex_noise_3d_fixed u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct {
        logic        op;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [7:0]  idx;
        logic [7:0]  val;
    } cmd_t;

    // our copy of the permutation table
    logic [7:0]  perm_copy [PERM_ENTRIES];
    logic [63:0] noise_q [$];
    int          errors;
    int          transfers_in;
    bit          pressure_done;

    // gradient components per index, values -1/0/+1
    int grad_x [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    int grad_y [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
    int grad_z [12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb failed");
        $finish;
    end

    // Q32.32 multiply: full signed product, floor shift by 32, keep low 64
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        return p[95:32];
    endfunction

    function automatic logic [7:0] perm_rd(input int unsigned i);
        return perm_copy[i & 255];
    endfunction

    function automatic logic [63:0] corner_term(input logic [63:0] dx, input logic [63:0] dy,
                                                input logic [63:0] dz, input int unsigned gi,
                                                input int unsigned gj, input int unsigned gk);
        logic [63:0] t;
        logic [63:0] dot;
        int          g;
        t = FX_FALLOFF - qmul(dx, dx) - qmul(dy, dy) - qmul(dz, dz);
        if (t[63])
            return 64'd0;   // outside the falloff radius
        t = qmul(t, t);
        g = perm_rd(gi + perm_rd(gj + perm_rd(gk))) % 12;
        dot = 64'd0;
        if (grad_x[g] > 0) dot = dot + dx; else if (grad_x[g] < 0) dot = dot - dx;
        if (grad_y[g] > 0) dot = dot + dy; else if (grad_y[g] < 0) dot = dot - dy;
        if (grad_z[g] > 0) dot = dot + dz; else if (grad_z[g] < 0) dot = dot - dz;
        return qmul(qmul(t, t), dot);
    endfunction

    function automatic logic [63:0] noise_at(input logic [63:0] x, input logic [63:0] y,
                                             input logic [63:0] z);
        logic [63:0] s, ci, cj, ck, t, x0, y0, z0, g2, g3, sum;
        int unsigned ii, jj, kk, i1, j1, k1, i2, j2, k2;
        s  = qmul(x + y + z, FX_F3);
        ci = (x + s) & 64'hFFFF_FFFF_0000_0000;
        cj = (y + s) & 64'hFFFF_FFFF_0000_0000;
        ck = (z + s) & 64'hFFFF_FFFF_0000_0000;
        t  = qmul(ci + cj + ck, FX_G3);
        x0 = x - (ci - t);
        y0 = y - (cj - t);
        z0 = z - (ck - t);
        ii = 32'(ci[39:32]);
        jj = 32'(cj[39:32]);
        kk = 32'(ck[39:32]);
        g2 = qmul(FX_G3, 2 * FX_ONE);
        g3 = qmul(FX_G3, 3 * FX_ONE);
        // simplex ordering
        if ($signed(x0) >= $signed(y0)) begin
            if ($signed(y0) >= $signed(z0)) begin
                {i1, j1, k1, i2, j2, k2} = {32'd1, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0};
            end else if ($signed(x0) >= $signed(z0)) begin
                {i1, j1, k1, i2, j2, k2} = {32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1};
            end else begin
                {i1, j1, k1, i2, j2, k2} = {32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd1};
            end
        end else begin
            if ($signed(y0) < $signed(z0)) begin
                {i1, j1, k1, i2, j2, k2} = {32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1};
            end else if ($signed(x0) < $signed(z0)) begin
                {i1, j1, k1, i2, j2, k2} = {32'd0, 32'd1, 32'd0, 32'd0, 32'd1, 32'd1};
            end else begin
                {i1, j1, k1, i2, j2, k2} = {32'd0, 32'd1, 32'd0, 32'd1, 32'd1, 32'd0};
            end
        end
        sum = corner_term(x0, y0, z0, ii, jj, kk);
        sum = sum + corner_term(x0 - (i1 ? FX_ONE : 64'd0) + FX_G3,
                                y0 - (j1 ? FX_ONE : 64'd0) + FX_G3,
                                z0 - (k1 ? FX_ONE : 64'd0) + FX_G3,
                                ii + i1, jj + j1, kk + k1);
        sum = sum + corner_term(x0 - (i2 ? FX_ONE : 64'd0) + g2,
                                y0 - (j2 ? FX_ONE : 64'd0) + g2,
                                z0 - (k2 ? FX_ONE : 64'd0) + g2,
                                ii + i2, jj + j2, kk + k2);
        sum = sum + corner_term(x0 - FX_ONE + g3, y0 - FX_ONE + g3, z0 - FX_ONE + g3,
                                ii + 1, jj + 1, kk + 1);
        return qmul(sum, 32 * FX_ONE);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // mostly near the origin so corners contribute; some full-range values
    function automatic logic [63:0] pick_coord();
        int ip;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        ip = $urandom_range(0, 600) - 300;
        return {ip[31:0], $urandom};
    endfunction

    task automatic send(input cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {c.val, c.idx, c.z, c.y, c.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transfer taken at this edge
        transfers_in++;
        if (c.op == OP_LOAD)
            perm_copy[c.idx] = c.val;
        else
            noise_q.push_back(noise_at(c.x, c.y, c.z));
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        pressure_done = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (!pressure_done && transfers_in > 400) begin
                m_tready <= 1'b0;
                repeat (1500) @(posedge aclk);
                pressure_done = 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_q.size() == 0) begin
                $error("noise_value: unexpected transfer, actual %h", m_tdata);
                errors++;
            end else begin
                logic [63:0] want;
                want = noise_q.pop_front();
                if (m_tdata !== want) begin
                    $error("noise_value: expected %h actual %h", want, m_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        cmd_t        dir [$];
        cmd_t        c;
        logic [7:0]  shuf [256];
        logic [7:0]  tmp;
        int          j;
        int          waited;

        errors = 0;
        transfers_in = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_LOAD;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole table first: a random permutation of 0..255
        for (int i = 0; i < 256; i++) shuf[i] = i[7:0];
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = shuf[i]; shuf[i] = shuf[j]; shuf[j] = tmp;
        end
        for (int i = 0; i < 256; i++) begin
            c = '{OP_LOAD, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, i[7:0], shuf[i]};
            send(c);
        end

        // directed samples: origin, extremes, each ordering, index wrap
        dir.push_back('{OP_SAMPLE, 64'h0, 64'h0, 64'h0, 8'hFF, 8'hFF});
        dir.push_back('{OP_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                        64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 8'h00});
        dir.push_back('{OP_SAMPLE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                        64'h8000_0000_0000_0000, 8'hFF, 8'h00});
        dir.push_back('{OP_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                        64'h0, 8'h00, 8'hFF});
        dir.push_back('{OP_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'hFFFF_FFFF_FFFF_FFFF, 8'h55, 8'hAA});
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_8000_0000, 64'h0000_0000_4000_0000,
                        64'h0000_0000_2000_0000, 8'h0, 8'h0});   // x > y > z
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_8000_0000, 64'h0000_0000_2000_0000,
                        64'h0000_0000_4000_0000, 8'h0, 8'h0});   // x > z > y
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_4000_0000, 64'h0000_0000_2000_0000,
                        64'h0000_0000_8000_0000, 8'h0, 8'h0});   // z > x > y
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_2000_0000, 64'h0000_0000_4000_0000,
                        64'h0000_0000_8000_0000, 8'h0, 8'h0});   // z > y > x
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_2000_0000, 64'h0000_0000_8000_0000,
                        64'h0000_0000_4000_0000, 8'h0, 8'h0});   // y > z > x
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_4000_0000, 64'h0000_0000_8000_0000,
                        64'h0000_0000_2000_0000, 8'h0, 8'h0});   // y > x > z
        // cell 255 on every axis: lookups wrap past the table end
        dir.push_back('{OP_SAMPLE, 64'h0000_00FF_9000_0000, 64'h0000_00FF_A000_0000,
                        64'h0000_00FF_B000_0000, 8'h0, 8'h0});
        dir.push_back('{OP_SAMPLE, 64'hFFFF_FFFF_7000_0000, 64'h0000_0001_1000_0000,
                        64'hFFFF_FF00_3000_0000, 8'h0, 8'h0});
        dir.push_back('{OP_SAMPLE, 64'h0000_0003_0000_0000, 64'h0000_0005_0000_0000,
                        64'h0000_0007_0000_0000, 8'h0, 8'h0});   // lattice point
        // a load mid-stream, then a sample that reads it
        dir.push_back('{OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 8'h00, 8'hFF});
        dir.push_back('{OP_SAMPLE, 64'h0000_0000_1000_0000, 64'h0000_0000_1000_0000,
                        64'h0000_0000_1000_0000, 8'h0, 8'h0});
        foreach (dir[i]) send(dir[i]);

        // random mix: mostly samples, some table rewrites
        repeat (680) begin
            if ($urandom_range(0, 9) == 0)
                c = '{OP_LOAD, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, 8'($urandom), 8'($urandom)};
            else
                c = '{OP_SAMPLE, pick_coord(), pick_coord(), pick_coord(),
                      8'($urandom), 8'($urandom)};
            send(c);
        end
        s_tvalid <= 1'b0;

        while (noise_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (errors == 0 && noise_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
